// ===== rtl/ip_address_text_classifier_core_macros.svh =====
// Assertion macros used by the address text classifier RTL.
`ifndef IP_ADDRESS_TEXT_CLASSIFIER_CORE_MACROS_SVH
`define IP_ADDRESS_TEXT_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPCLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPCLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ipcls_pkg.sv =====
// Types and constants of the address text classifier.
`timescale 1ns / 1ps
package ipcls_pkg;

  typedef enum logic [1:0] {
    CLASS_V4   = 2'd0,
    CLASS_V6   = 2'd1,
    CLASS_NONE = 2'd2
  } addr_class_e;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;

  localparam logic [7:0]  DEC_MAX_VALUE  = 8'd255;
  localparam logic [1:0]  DEC_MAX_DIGITS = 2'd3;
  localparam logic [2:0]  HEX_MAX_DIGITS = 3'd4;
  localparam logic [2:0]  DEC_LAST_GROUP = 3'd3;
  localparam logic [3:0]  HEX_LAST_GROUP = 4'd7;
  localparam logic [2:0]  DEC_GROUP_SAT  = 3'd7;
  localparam logic [3:0]  HEX_GROUP_SAT  = 4'd15;

  typedef struct packed {
    logic       dec_alive;
    logic [2:0] dec_groups;
    logic [1:0] dec_digits;
    logic [7:0] dec_value;
    logic       dec_zero;
    logic       hex_alive;
    logic [3:0] hex_groups;
    logic [2:0] hex_digits;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    dec_alive:  1'b1,
    dec_groups: 3'd0,
    dec_digits: 2'd0,
    dec_value:  8'd0,
    dec_zero:   1'b0,
    hex_alive:  1'b1,
    hex_groups: 4'd0,
    hex_digits: 3'd0
  };

endpackage

// ===== rtl/ip_address_text_classifier_core.sv =====
// Top level of the IPv4 / IPv6 address text classifier.
// A final character sits in the input register before its result is registered.
// Throughput: one character per cycle unless a final one waits on an untaken result.
// The checker state and input register advance together, so strings run back to back.
// Reset: rst_ni clears the scan state to "both forms alive", empties both registers.
`timescale 1ns / 1ps
`include "ip_address_text_classifier_core_macros.svh"
module ip_address_text_classifier_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] address_class_o
);
  import ipcls_pkg::*;

  // Input register: one character beat waiting to be scanned.
  logic        in_valid_q, in_valid_d;
  logic [7:0]  char_q;
  logic        last_q;

  // Running scan state of the current string.
  scan_state_t state_q, state_d, state_next;
  addr_class_e class_next;

  // Result register.
  logic        out_valid_q, out_valid_d;
  addr_class_e class_q;

  logic advance;   // the held character is folded into the scan state this cycle
  logic in_take;   // a new character beat is accepted this cycle
  logic finish;    // the held character ends its string

  ipcls_step u_step (
    .state_i     (state_q),
    .char_code_i (char_q),
    .state_o     (state_next),
    .class_o     (class_next)
  );

  // A non-final character never waits on the result side; a final one waits
  // only while an earlier result is still held and not being taken.
  assign advance = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign finish  = advance && last_q;

  // Take a new beat whenever the input register is empty or draining.
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Fold the character in; drop back to the reset state after the final one.
  always_comb begin
    state_d = state_q;
    if (finish) begin
      state_d = SCAN_RESET;
    end else if (advance) begin
      state_d = state_next;
    end
  end

  // Hold the result until the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= SCAN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
    if (finish) begin
      class_q <= class_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign address_class_o = class_q;

  // A string end always restarts the checkers from their reset state.
  `IPCLS_ASSERT_NEXT(a_reset_after_last, clk_i, rst_ni, finish, state_q == SCAN_RESET)
  // A dead form stays dead until the string ends.
  `IPCLS_ASSERT_NEXT(a_dec_stays_dead, clk_i, rst_ni,
                     !state_q.dec_alive && !finish, !state_q.dec_alive)
  `IPCLS_ASSERT_NEXT(a_hex_stays_dead, clk_i, rst_ni,
                     !state_q.hex_alive && !finish, !state_q.hex_alive)
  // Backpressure on the input side only comes from a held character.
  `IPCLS_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !in_valid_q, in_ready_o)
  // A shown result is never the unused class code.
  `IPCLS_ASSERT_NOW(a_class_legal, clk_i, rst_ni, out_valid_q,
                    class_q == CLASS_V4 || class_q == CLASS_V6 || class_q == CLASS_NONE)

endmodule

// ===== rtl/ipcls_step.sv =====
// Per-character update of both address form checkers and the final verdict.
`timescale 1ns / 1ps
module ipcls_step (
  input  ipcls_pkg::scan_state_t state_i,
  input  logic [7:0]             char_code_i,
  output ipcls_pkg::scan_state_t state_o,
  output ipcls_pkg::addr_class_e class_o
);
  import ipcls_pkg::*;

  logic        is_dec;
  logic        is_hex;
  logic [3:0]  digit;
  logic [11:0] dec_next_value;

  assign is_dec = char_code_i inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_hex = is_dec || (char_code_i inside {[CHAR_UC_A:CHAR_UC_F], [CHAR_LC_A:CHAR_LC_F]});
  assign digit  = char_code_i[3:0];
  // value * 10 + digit as shifts and adds
  assign dec_next_value = {1'b0, state_i.dec_value, 3'b000}
                        + {3'b000, state_i.dec_value, 1'b0}
                        + {8'd0, digit};

  always_comb begin
    state_o = state_i;
    // dotted-decimal form
    if (state_i.dec_alive) begin
      if (char_code_i == CHAR_DOT) begin
        if (state_i.dec_digits == 2'd0) begin
          state_o.dec_alive = 1'b0;
        end else begin
          if (state_i.dec_groups != DEC_GROUP_SAT) begin
            state_o.dec_groups = state_i.dec_groups + 3'd1;
          end
          state_o.dec_digits = 2'd0;
          state_o.dec_value  = 8'd0;
          state_o.dec_zero   = 1'b0;
        end
      end else if (is_dec) begin
        if (state_i.dec_digits >= DEC_MAX_DIGITS) begin
          state_o.dec_alive = 1'b0;
        end else if (state_i.dec_digits != 2'd0 && state_i.dec_zero) begin
          state_o.dec_alive = 1'b0;
        end else if (dec_next_value > {4'd0, DEC_MAX_VALUE}) begin
          state_o.dec_alive = 1'b0;
        end else begin
          if (state_i.dec_digits == 2'd0) begin
            state_o.dec_zero = (char_code_i == CHAR_ZERO);
          end
          state_o.dec_value  = dec_next_value[7:0];
          state_o.dec_digits = state_i.dec_digits + 2'd1;
        end
      end else begin
        state_o.dec_alive = 1'b0;
      end
    end
    // colon-hex form
    if (state_i.hex_alive) begin
      if (char_code_i == CHAR_COLON) begin
        if (state_i.hex_digits == 3'd0) begin
          state_o.hex_alive = 1'b0;
        end else begin
          if (state_i.hex_groups != HEX_GROUP_SAT) begin
            state_o.hex_groups = state_i.hex_groups + 4'd1;
          end
          state_o.hex_digits = 3'd0;
        end
      end else if (is_hex) begin
        if (state_i.hex_digits >= HEX_MAX_DIGITS) begin
          state_o.hex_alive = 1'b0;
        end else begin
          state_o.hex_digits = state_i.hex_digits + 3'd1;
        end
      end else begin
        state_o.hex_alive = 1'b0;
      end
    end
  end

  always_comb begin
    if (state_o.dec_alive && state_o.dec_digits != 2'd0 &&
        state_o.dec_groups == DEC_LAST_GROUP) begin
      class_o = CLASS_V4;
    end else if (state_o.hex_alive && state_o.hex_digits != 3'd0 &&
                 state_o.hex_groups == HEX_LAST_GROUP) begin
      class_o = CLASS_V6;
    end else begin
      class_o = CLASS_NONE;
    end
  end

endmodule

// ===== verif/ip_address_text_classifier_core_tb.sv =====
// Testbench of the IPv4 / IPv6 address text classifier: directed and random strings checked against a predictor.
`timescale 1ns / 1ps
module ip_address_text_classifier_core_tb;
  import ipcls_pkg::*;

  // One character beat as the driver offers it.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_beat_t;

  // Predictor copy of both checkers; the group value keeps the full 10 bits.
  typedef struct {
    logic       dec_ok;
    logic [2:0] dec_grp;
    logic [1:0] dec_dig;
    logic [9:0] dec_val;
    logic       dec_lead0;
    logic       hex_ok;
    logic [3:0] hex_grp;
    logic [2:0] hex_dig;
  } scan_t;

  localparam int RANDOM_CHARS = 1100;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD_CYCLES = 300;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_code = 8'h00;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] address_class;

  char_beat_t  char_pending_q[$];
  logic [7:0]  text_q[$];
  addr_class_e class_expected_q[$];
  scan_t       scan;

  int   mismatch_count = 0;
  int   chars_accepted = 0;
  logic in_beat_taken = 1'b0;
  logic long_hold_active = 1'b0;

  // Driver and receiver bookkeeping, each touched by its own process only.
  char_beat_t next_beat;
  int         tx_gap_left = 0;
  int         tx_calm_left = 0;
  int         rx_hold_left = 0;
  int         rx_calm_left = 0;
  int         rx_stall;
  bit         long_hold_done = 1'b0;

  ip_address_text_classifier_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_code_i    (char_code),
    .last_char_i    (last_char),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .address_class_o(address_class)
  );

  always #4 clk_i = ~clk_i;

  function automatic scan_t fresh_scan();
    scan_t s;
    s.dec_ok    = 1'b1;
    s.dec_grp   = '0;
    s.dec_dig   = '0;
    s.dec_val   = '0;
    s.dec_lead0 = 1'b0;
    s.hex_ok    = 1'b1;
    s.hex_grp   = '0;
    s.hex_dig   = '0;
    return s;
  endfunction

  // Advance both checkers by one character; on the final one, queue the class and restart.
  task automatic classify_char(input logic [7:0] c, input logic last);
    int unsigned v;
    logic        v4;
    logic        v6;
    if (scan.dec_ok) begin
      if (c == CHAR_DOT) begin
        // A dot with no digit before it is an empty group.
        if (scan.dec_dig == 0) begin
          scan.dec_ok = 1'b0;
        end else begin
          if (scan.dec_grp != DEC_GROUP_SAT) scan.dec_grp++;
          scan.dec_dig   = '0;
          scan.dec_val   = '0;
          scan.dec_lead0 = 1'b0;
        end
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        if (scan.dec_dig >= DEC_MAX_DIGITS) begin
          scan.dec_ok = 1'b0;
        end else if (scan.dec_dig != 0 && scan.dec_lead0) begin
          scan.dec_ok = 1'b0;
        end else begin
          if (scan.dec_dig == 0) scan.dec_lead0 = (c == CHAR_ZERO);
          v = int'(scan.dec_val) * 10 + int'(c - CHAR_ZERO);
          if (v > DEC_MAX_VALUE) begin
            scan.dec_ok = 1'b0;
          end else begin
            scan.dec_val = v[9:0];
            scan.dec_dig++;
          end
        end
      end else begin
        scan.dec_ok = 1'b0;
      end
    end
    if (scan.hex_ok) begin
      if (c == CHAR_COLON) begin
        if (scan.hex_dig == 0) begin
          scan.hex_ok = 1'b0;
        end else begin
          if (scan.hex_grp != HEX_GROUP_SAT) scan.hex_grp++;
          scan.hex_dig = '0;
        end
      end else if ((c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UC_A && c <= CHAR_UC_F) ||
                   (c >= CHAR_LC_A && c <= CHAR_LC_F)) begin
        if (scan.hex_dig >= HEX_MAX_DIGITS) scan.hex_ok = 1'b0;
        else scan.hex_dig++;
      end else begin
        scan.hex_ok = 1'b0;
      end
    end
    if (last) begin
      v4 = scan.dec_ok && scan.dec_dig != 0 && scan.dec_grp == DEC_LAST_GROUP;
      v6 = scan.hex_ok && scan.hex_dig != 0 && scan.hex_grp == HEX_LAST_GROUP;
      class_expected_q.push_back(v4 ? CLASS_V4 : (v6 ? CLASS_V6 : CLASS_NONE));
      scan = fresh_scan();
    end
  endtask

  // Idle length: mostly zero, some short, a few long; occasional calm stretches with none.
  function automatic int pick_idle(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 99) == 0) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Move the text under construction into the pending beats, flag on its final character.
  task automatic commit_text();
    char_beat_t b;
    if (text_q.size() == 0) text_q.push_back(CHAR_ZERO);
    foreach (text_q[i]) begin
      b.code = text_q[i];
      b.last = (i == text_q.size() - 1);
      char_pending_q.push_back(b);
    end
    text_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    commit_text();
  endtask

  task automatic build_v4_text();
    int    groups;
    int    r;
    string s;
    r = $urandom_range(0, 99);
    groups = (r < 85) ? 4 : (r < 90) ? 3 : (r < 95) ? 5 : $urandom_range(6, 10);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) text_q.push_back(CHAR_DOT);
      r = $urandom_range(0, 99);
      if (r < 5) s = $sformatf("0%0d", $urandom_range(0, 99));
      else if (r < 8) s = $sformatf("%0d", $urandom_range(1000, 9999));
      else if (r < 14) s = $sformatf("%0d", $urandom_range(256, 999));
      else if (r < 22) s = $sformatf("%0d", $urandom_range(250, 255));
      else if (r < 45) s = $sformatf("%0d", $urandom_range(0, 9));
      else if (r < 65) s = $sformatf("%0d", $urandom_range(10, 99));
      else s = $sformatf("%0d", $urandom_range(100, 255));
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    end
  endtask

  task automatic build_v6_text();
    int         groups;
    int         len;
    int         d;
    int         r;
    logic [7:0] letter_base;
    r = $urandom_range(0, 99);
    groups = (r < 85) ? 8 : (r < 90) ? 7 : (r < 95) ? 9 : $urandom_range(15, 17);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) text_q.push_back(CHAR_COLON);
      len = ($urandom_range(0, 99) < 4) ? 5 : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        d = $urandom_range(0, 15);
        letter_base = $urandom_range(0, 1) ? CHAR_LC_A : CHAR_UC_A;
        if (d < 10) text_q.push_back(CHAR_ZERO + 8'(d));
        else text_q.push_back(letter_base + 8'(d - 10));
      end
    end
  endtask

  // Break a well-formed string in one place.
  task automatic mutate_text();
    int         pos;
    logic [7:0] sep;
    pos = $urandom_range(0, text_q.size() - 1);
    sep = $urandom_range(0, 1) ? CHAR_DOT : CHAR_COLON;
    case ($urandom_range(0, 5))
      0: text_q[pos] = 8'($urandom_range(0, 255));
      1: text_q[pos] = sep;
      2: text_q.delete(pos);
      3: text_q.insert(pos, sep);
      4: text_q.push_back(sep);
      default: text_q.push_front(sep);
    endcase
  endtask

  // Noise leans on the characters just outside each digit range.
  task automatic build_noise_text();
    string pool;
    int    len;
    pool = "0123456789:./@AFGafg`;-";
    len = $urandom_range(1, 12);
    repeat (len) begin
      if ($urandom_range(0, 99) < 40) text_q.push_back(8'($urandom_range(0, 255)));
      else text_q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    end
  endtask

  // Driver: present a new beat at the falling edge once the previous one is gone.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_beat_taken)) begin
      if (tx_gap_left > 0 && !long_hold_active) begin
        tx_gap_left--;
        in_valid <= 1'b0;
      end else if (char_pending_q.size() != 0) begin
        next_beat = char_pending_q.pop_front();
        char_code <= next_beat.code;
        last_char <= next_beat.last;
        in_valid  <= 1'b1;
        tx_gap_left = pick_idle(tx_calm_left);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up to its input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && chars_accepted >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        rx_hold_left = LONG_HOLD_CYCLES - 1;
        long_hold_active <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        long_hold_active <= 1'b0;
        rx_stall = pick_idle(rx_calm_left);
        if (rx_stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          rx_hold_left = rx_stall - 1;
        end
      end
    end
  end

  // Monitor: predict on every accepted character, check every accepted result beat.
  always @(posedge clk_i) begin
    in_beat_taken <= in_valid && in_ready;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        chars_accepted++;
        classify_char(char_code, last_char);
      end
      if (out_valid && out_ready) begin
        if (class_expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual class %0d",
                   $time, address_class);
          mismatch_count++;
        end else if (address_class !== class_expected_q[0]) begin
          $display("%0t: class mismatch, expected %0d, actual %0d",
                   $time, class_expected_q[0], address_class);
          mismatch_count++;
          void'(class_expected_q.pop_front());
        end else begin
          void'(class_expected_q.pop_front());
        end
      end
    end
  end

  initial begin
    int r;
    scan = fresh_scan();

    // Directed strings: smallest IPv4, lone and trailing separators, leading zero,
    // overlong group, foreign characters, and the extreme character codes.
    push_text("0.0.0.0");
    push_text(".");
    push_text(":");
    push_text("1.");
    push_text("01");
    push_text("12345");
    push_text("g");
    push_text("A:b");
    text_q.push_back(8'h00);
    commit_text();
    text_q.push_back(8'hFF);
    commit_text();

    // Random strings: mostly well-formed, some broken in one or two places, some noise.
    while (char_pending_q.size() < RANDOM_CHARS) begin
      r = $urandom_range(0, 99);
      if (r < 45) build_v4_text();
      else if (r < 85) build_v6_text();
      else build_noise_text();
      if (r < 85 && $urandom_range(0, 99) < 25) begin
        mutate_text();
        if (text_q.size() != 0 && $urandom_range(0, 3) == 0) mutate_text();
      end
      commit_text();
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all beats offered and taken, all results back, then let the pipe settle.
    while (char_pending_q.size() != 0 || in_valid) @(posedge clk_i);
    while (class_expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
